// ----- rtl/bfw_pkg.sv -----
// Shared types and constants for the BMP stream writer.
`timescale 1ns / 1ps
package bfw_pkg;

	localparam int DEF_MAX_DIM = 16384;

	localparam int CFG_DIM_W  = 15;
	localparam int CFG_DATA_W = 15;
	localparam int CFG_IDX_W  = 2;

	localparam logic [31:0] PPM_DEFAULT   = 32'd2835;
	localparam logic [31:0] MASK_RED      = 32'h00FF0000;
	localparam logic [31:0] MASK_GREEN    = 32'h0000FF00;
	localparam logic [31:0] MASK_BLUE     = 32'h000000FF;
	localparam logic [31:0] FILE_HDR_SIZE = 32'd14;
	localparam logic [31:0] INFO_HDR_SIZE = 32'd40;
	localparam logic [31:0] MASK_BLK_SIZE = 32'd12;

	// compression field codes
	localparam logic [31:0] COMPRESS_NONE  = 32'd0;
	localparam logic [31:0] COMPRESS_MASKS = 32'd3;

	// full header words; the last two header bytes stay pending
	localparam logic [4:0] HDR_WORDS_24 = 5'd13;
	localparam logic [4:0] HDR_WORDS_32 = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_MODE   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_DIM  = 2'd1,
		STAT_PAST_END = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  bytes_valid;
		logic        last;
		logic [1:0]  nwords;
		logic [23:0] nxt_pend;
		logic [1:0]  nxt_pcnt;
	} pack_out_t;

endpackage

// ----- rtl/bfw_pixel_if.sv -----
// Pixel request channel.
`timescale 1ns / 1ps
interface bfw_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// ----- rtl/bfw_word_if.sv -----
// Output word request channel.
`timescale 1ns / 1ps
interface bfw_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_word;
	logic [2:0]  bytes_valid;
	logic        last;
	logic [1:0]  status;

	modport source (output valid, out_word, bytes_valid, last, status, input ready);
	modport sink   (input valid, out_word, bytes_valid, last, status, output ready);
endinterface

// ----- rtl/bfw_hdr_gen.sv -----
// BMP file and info header generator, one 32-bit word per index.
`timescale 1ns / 1ps
module bfw_hdr_gen (
	input  logic                          clk,
	input  logic [bfw_pkg::CFG_DIM_W-1:0] width,
	input  logic [bfw_pkg::CFG_DIM_W-1:0] height,
	input  logic                          mode,
	input  logic [3:0]                    word_idx,
	output logic [31:0]                   word,
	output logic [15:0]                   tail
);
	import bfw_pkg::*;

	logic [16:0]  stride;
	logic [31:0]  pix_q;
	logic [31:0]  off;
	logic [31:0]  fsize;
	logic [527:0] hdr;

	always_comb begin
		if (mode) begin
			stride = {width, 2'b00};
		end else begin
			stride = (17'(width) * 17'd3 + 17'd3) & ~17'd3;
		end
	end

	always_ff @(posedge clk) begin
		pix_q <= 32'(height) * 32'(stride);
	end

	assign off   = FILE_HDR_SIZE + INFO_HDR_SIZE + (mode ? MASK_BLK_SIZE : 32'd0);
	assign fsize = off + pix_q;

	// little endian: first byte at bit 0
	assign hdr = {
		MASK_BLUE, MASK_GREEN, MASK_RED,
		32'd0, 32'd0, PPM_DEFAULT, PPM_DEFAULT, pix_q,
		(mode ? COMPRESS_MASKS : COMPRESS_NONE),
		(mode ? 16'd32 : 16'd24), 16'd1,
		32'(height), 32'(width), INFO_HDR_SIZE, off,
		16'd0, 16'd0, fsize,
		8'h4D, 8'h42
	};

	assign word = hdr[32*word_idx +: 32];
	assign tail = mode ? hdr[527:512] : hdr[431:416];

endmodule

// ----- rtl/bfw_pack.sv -----
// Merges held bytes, pixel bytes and row padding into output words.
`timescale 1ns / 1ps
module bfw_pack (
	input  logic                 mode,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	input  logic [7:0]           alpha,
	input  logic [23:0]          pend,
	input  logic [1:0]           pcnt,
	input  logic [1:0]           pad,
	input  logic                 final_px,
	input  logic [1:0]           k,
	output bfw_pkg::pack_out_t   po
);
	import bfw_pkg::*;

	logic [31:0] nb;
	logic [3:0]  n;
	logic [3:0]  t;
	logic [79:0] m;
	logic [1:0]  full;
	logic [1:0]  rem;
	logic [31:0] wsel;
	logic [31:0] wfull;

	assign nb = {(mode ? alpha : 8'd0), red, green, blue};
	assign n  = 4'd3 + 4'(mode) + 4'(pad);
	assign t  = 4'(pcnt) + n;
	assign m  = 80'(pend) | (80'(nb) << {pcnt, 3'b000});
	assign full = t[3:2];
	assign rem  = t[1:0];

	always_comb begin
		case (k)
			2'd0:    wsel = m[31:0];
			2'd1:    wsel = m[63:32];
			default: wsel = 32'(m[79:64]);
		endcase
		case (full)
			2'd0:    wfull = m[31:0];
			2'd1:    wfull = m[63:32];
			default: wfull = 32'(m[79:64]);
		endcase
	end

	always_comb begin
		po.word   = wsel;
		po.nwords = full + 2'((final_px && rem != 2'd0) ? 1 : 0);
		if (k < full) begin
			po.bytes_valid = 3'd4;
			po.last        = final_px && rem == 2'd0 && k == full - 2'd1;
		end else begin
			po.bytes_valid = 3'(rem);
			po.last        = 1'b1;
		end
		po.nxt_pend = final_px ? 24'd0 : wfull[23:0];
		po.nxt_pcnt = final_px ? 2'd0 : rem;
	end

endmodule

// ----- rtl/bmp_file_writer_stream_top.sv -----
// BMP stream writer top level: pixel register, sequencing and output word register.
`timescale 1ns / 1ps
// Takes one RGBA pixel per request in file order (bottom row first) and emits
// the BMP file as 32-bit little-endian words through a single output word
// register, one word per cycle while the sink is ready. A pixel gives up to
// two full words, and the final pixel up to three (the flush word). The first
// pixel of an image waits while the size product is registered and then the
// header words are sent, more of them in 32-bit mode. Bad dimensions or pixels
// after the image end give one status word each. Configuration is written
// through cfg_we/cfg_idx/cfg_data.
module bmp_file_writer_stream_top #(
	parameter int MAX_DIM = bfw_pkg::DEF_MAX_DIM
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bfw_pixel_if.sink                      pix,
	bfw_word_if.source                     res,
	input  logic                           cfg_we,
	input  logic [bfw_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bfw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bfw_pkg::*;

	localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	logic [CFG_DIM_W-1:0] width_q, height_q;
	logic                 mode_q;

	logic       s1_valid_q;
	logic [7:0] red_s1, green_s1, blue_s1, alpha_s1;

	logic [4:0]       hdr_idx_q;
	logic [1:0]       wrd_idx_q;
	logic [CNT_W-1:0] col_q, row_q;
	logic             hdr_sent_q, done_q;
	logic [23:0]      pend_q;
	logic [1:0]       pcnt_q;

	logic        res_valid_q;
	logic [31:0] res_word_q;
	logic [2:0]  res_bv_q;
	logic        res_last_q;
	status_t     res_stat_q;

	logic        bad_dim, row_end, col_end_img, final_px, can_load;
	logic [1:0]  pad;
	logic [4:0]  hdr_words;
	logic [3:0]  hdr_widx;
	logic [31:0] hdr_word;
	logic [15:0] hdr_tail;
	pack_out_t   po;

	logic        emit, retire, px_retire, hdr_adv, hdr_done;
	logic [31:0] e_word;
	logic [2:0]  e_bv;
	logic        e_last;
	status_t     e_stat;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_DIM_W'(1);
			height_q <= CFG_DIM_W'(1);
			mode_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_MODE:   mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign bad_dim = width_q == '0 || height_q == '0 ||
		17'(width_q) > 17'(MAX_DIM) || 17'(height_q) > 17'(MAX_DIM);
	assign row_end     = 17'(col_q) + 17'd1 >= 17'(width_q);
	assign col_end_img = 17'(row_q) + 17'd1 >= 17'(height_q);
	assign final_px    = row_end && col_end_img;
	assign pad         = (!mode_q && row_end) ? width_q[1:0] : 2'd0;
	assign hdr_words   = mode_q ? HDR_WORDS_32 : HDR_WORDS_24;
	assign hdr_widx    = 4'(hdr_idx_q - 5'd1);
	assign can_load    = !res_valid_q || res.ready;

	bfw_hdr_gen u_hdr (
		.clk      (clk),
		.width    (width_q),
		.height   (height_q),
		.mode     (mode_q),
		.word_idx (hdr_widx),
		.word     (hdr_word),
		.tail     (hdr_tail)
	);

	bfw_pack u_pack (
		.mode     (mode_q),
		.red      (red_s1),
		.green    (green_s1),
		.blue     (blue_s1),
		.alpha    (alpha_s1),
		.pend     (pend_q),
		.pcnt     (pcnt_q),
		.pad      (pad),
		.final_px (final_px),
		.k        (wrd_idx_q),
		.po       (po)
	);

	// per-cycle sequencing of the held pixel
	always_comb begin
		emit      = 1'b0;
		retire    = 1'b0;
		px_retire = 1'b0;
		hdr_adv   = 1'b0;
		hdr_done  = 1'b0;
		e_word    = '0;
		e_bv      = '0;
		e_last    = 1'b0;
		e_stat    = STAT_OK;
		if (s1_valid_q) begin
			if (done_q) begin
				emit   = 1'b1;
				e_stat = STAT_PAST_END;
				retire = can_load;
			end else if (bad_dim) begin
				emit   = 1'b1;
				e_stat = STAT_BAD_DIM;
				retire = can_load;
			end else if (!hdr_sent_q) begin
				if (hdr_idx_q == '0) begin
					hdr_adv = 1'b1;
				end else begin
					emit   = 1'b1;
					e_word = hdr_word;
					e_bv   = 3'd4;
					if (can_load) begin
						hdr_done = hdr_idx_q == hdr_words;
						hdr_adv  = !hdr_done;
					end
				end
			end else if (po.nwords == 2'd0) begin
				retire    = 1'b1;
				px_retire = 1'b1;
			end else begin
				emit      = 1'b1;
				e_word    = po.word;
				e_bv      = po.bytes_valid;
				e_last    = po.last;
				px_retire = can_load && wrd_idx_q == po.nwords - 2'd1;
				retire    = px_retire;
			end
		end
	end

	assign pix.ready = !s1_valid_q || retire;

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) begin
			red_s1   <= pix.red;
			green_s1 <= pix.green;
			blue_s1  <= pix.blue;
			alpha_s1 <= pix.alpha;
		end
		if (emit && can_load) begin
			res_word_q <= e_word;
			res_bv_q   <= e_bv;
			res_last_q <= e_last;
			res_stat_q <= e_stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
			hdr_idx_q   <= '0;
			wrd_idx_q   <= '0;
			col_q       <= '0;
			row_q       <= '0;
			hdr_sent_q  <= 1'b0;
			done_q      <= 1'b0;
			pend_q      <= '0;
			pcnt_q      <= '0;
		end else begin
			if (pix.valid && pix.ready) begin
				s1_valid_q <= 1'b1;
			end else if (retire) begin
				s1_valid_q <= 1'b0;
			end

			if (emit && can_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			if (hdr_adv) begin
				hdr_idx_q <= hdr_idx_q + 5'd1;
			end
			if (hdr_done) begin
				hdr_idx_q  <= '0;
				hdr_sent_q <= 1'b1;
				pend_q     <= {8'd0, hdr_tail};
				pcnt_q     <= 2'd2;
			end

			if (s1_valid_q && hdr_sent_q && !done_q && !bad_dim && emit && can_load
				&& !px_retire) begin
				wrd_idx_q <= wrd_idx_q + 2'd1;
			end

			if (px_retire) begin
				wrd_idx_q <= '0;
				pend_q    <= po.nxt_pend;
				pcnt_q    <= po.nxt_pcnt;
				if (row_end) begin
					col_q <= '0;
					if (col_end_img) begin
						done_q <= 1'b1;
					end else begin
						row_q <= row_q + CNT_W'(1);
					end
				end else begin
					col_q <= col_q + CNT_W'(1);
				end
			end
		end
	end

	assign res.valid       = res_valid_q;
	assign res.out_word    = res_word_q;
	assign res.bytes_valid = res_bv_q;
	assign res.last        = res_last_q;
	assign res.status      = res_stat_q;

endmodule

// ----- rtl/bfw_checker.sv -----
// Port-level checks on the BMP stream writer output, bound to the top level.
`timescale 1ns / 1ps
module bfw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_word,
	input logic [2:0]  res_bv,
	input logic        res_last,
	input logic [1:0]  res_status
);
	import bfw_pkg::*;

	// status words carry no file bytes
	a_stat_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != STAT_OK |->
			res_word == '0 && res_bv == '0 && !res_last)
		else $error("status word carries data");

	// a short word only ends the file
	a_short_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STAT_OK && res_bv != 3'd4 |-> res_last)
		else $error("partial word without last");

	a_bv_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STAT_OK |-> res_bv != 3'd0 && res_bv <= 3'd4)
		else $error("bytes_valid out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			res_valid && $stable(res_word) && $stable(res_bv) && $stable(res_last))
		else $error("stalled request changed");

endmodule

bind bmp_file_writer_stream_top bfw_checker u_bfw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_word   (res.out_word),
	.res_bv     (res.bytes_valid),
	.res_last   (res.last),
	.res_status (res.status)
);

// ----- sim/bmp_file_writer_stream_top_tb.sv -----
// Self-checking testbench for the BMP stream writer: random pixel traffic checked word by word.
`timescale 1ns / 1ps
module bmp_file_writer_stream_top_tb;
	import bfw_pkg::*;

	localparam int unsigned MAX_DIM      = DEF_MAX_DIM;
	localparam int unsigned TARGET_ITEMS = 470;
	localparam int unsigned SETTLE       = 24;
	localparam int unsigned STALL_LIMIT  = 4000;

	typedef enum logic {
		MODE_BGR24  = 1'b0,
		MODE_BGRA32 = 1'b1
	} color_mode_t;

	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_COIN,
		PACE_THIRD,
		PACE_MOSTLY
	} sink_pace_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} bmp_pixel_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
		status_t     status;
	} bmp_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	bfw_pixel_if pix_if();
	bfw_word_if  word_if();

	bmp_file_writer_stream_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_if),
		.res(word_if),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predictor state
	int unsigned  img_w, img_h;
	color_mode_t  img_mode;
	int unsigned  col_cnt, row_cnt;
	bit           hdr_done, img_done;
	logic [31:0]  pend_bytes;
	int unsigned  pend_cnt;
	int unsigned  hdr_bpp;

	bmp_pixel_t   pixel_q[$];
	bmp_word_t    word_q[$];

	int unsigned  errors, pixels_taken, words_seen, bad_dim_seen, past_end_seen;
	int unsigned  idle_cycles;
	logic         pix_taken;
	int unsigned  burst_left, gap_left;
	int unsigned  pace_cycle;
	sink_pace_t   pace;
	bmp_pixel_t   drv_pixel;

	function void queue_word(logic [31:0] w, logic [2:0] n, logic l, status_t s);
		bmp_word_t e;
		e.word   = w;
		e.nbytes = n;
		e.last   = l;
		e.status = s;
		word_q.insert(word_q.size(), e);
	endfunction

	function void add_pixel(bmp_pixel_t p);
		pixel_q.insert(pixel_q.size(), p);
	endfunction

	function void pack_byte(logic [7:0] b);
		pend_bytes = pend_bytes | (32'(b) << (8 * pend_cnt));
		pend_cnt++;
		if (pend_cnt == 4) begin
			queue_word(pend_bytes, 3'd4, 1'b0, STAT_OK);
			pend_bytes = '0;
			pend_cnt   = 0;
		end
	endfunction

	function void pack16(logic [15:0] v);
		pack_byte(v[7:0]);
		pack_byte(v[15:8]);
	endfunction

	function void pack32(logic [31:0] v);
		for (int i = 0; i < 4; i++)
			pack_byte(v[8*i +: 8]);
	endfunction

	function void pack_header();
		logic [63:0] row_data;
		logic [31:0] stride, img_bytes, offset;
		row_data  = 64'(img_w) * ((img_mode == MODE_BGRA32) ? 64'd4 : 64'd3);
		stride    = 32'((row_data + 64'd3) & ~64'd3);
		img_bytes = 32'(64'(img_h) * 64'(stride));
		offset    = FILE_HDR_SIZE + INFO_HDR_SIZE +
			((img_mode == MODE_BGRA32) ? MASK_BLK_SIZE : 32'd0);
		hdr_bpp   = (img_mode == MODE_BGRA32) ? 32 : 24;
		pack_byte("B");
		pack_byte("M");
		pack32(offset + img_bytes);
		pack16(16'd0);
		pack16(16'd0);
		pack32(offset);
		pack32(INFO_HDR_SIZE);
		pack32(img_w);
		pack32(img_h);
		pack16(16'd1);
		pack16(16'(hdr_bpp));
		pack32((img_mode == MODE_BGRA32) ? COMPRESS_MASKS : COMPRESS_NONE);
		pack32(img_bytes);
		pack32(PPM_DEFAULT);
		pack32(PPM_DEFAULT);
		pack32(32'd0);
		pack32(32'd0);
		if (img_mode == MODE_BGRA32) begin
			pack32(MASK_RED);
			pack32(MASK_GREEN);
			pack32(MASK_BLUE);
		end
	endfunction

	function void predict_pixel(bmp_pixel_t p);
		int unsigned first, pad;
		if (img_done) begin
			queue_word(32'd0, 3'd0, 1'b0, STAT_PAST_END);
			return;
		end
		if (img_w == 0 || img_h == 0 || img_w > MAX_DIM || img_h > MAX_DIM) begin
			queue_word(32'd0, 3'd0, 1'b0, STAT_BAD_DIM);
			return;
		end
		first = word_q.size();
		if (!hdr_done) begin
			pack_header();
			hdr_done = 1'b1;
		end
		pack_byte(p.blue);
		pack_byte(p.green);
		pack_byte(p.red);
		if (img_mode == MODE_BGRA32)
			pack_byte(p.alpha);
		if (col_cnt + 1 >= img_w) begin
			pad = (img_mode == MODE_BGRA32) ? 0 : ((4 - ((img_w * 3) & 3)) & 3);
			for (int k = 0; k < pad; k++)
				pack_byte(8'd0);
			col_cnt = 0;
			if (row_cnt + 1 >= img_h) begin
				img_done = 1'b1;
				if (pend_cnt > 0)
					queue_word(pend_bytes, 3'(pend_cnt), 1'b1, STAT_OK);
				else if (word_q.size() > first)
					word_q[word_q.size() - 1].last = 1'b1;
				pend_bytes = '0;
				pend_cnt   = 0;
			end else begin
				row_cnt++;
			end
		end else begin
			col_cnt++;
		end
	endfunction

	task report_mismatch(string msg);
		$display("ERROR %0t: %s", $time, msg);
		errors++;
	endtask

	task check_word();
		bmp_word_t e;
		words_seen++;
		if (word_if.status == STAT_BAD_DIM)
			bad_dim_seen++;
		if (word_if.status == STAT_PAST_END)
			past_end_seen++;
		if (word_q.size() == 0) begin
			report_mismatch($sformatf("unexpected word %08h", word_if.out_word));
			return;
		end
		e = word_q.pop_front();
		if (word_if.out_word !== e.word)
			report_mismatch($sformatf("word %0d: out_word %08h, want %08h",
				words_seen, word_if.out_word, e.word));
		if (word_if.bytes_valid !== e.nbytes)
			report_mismatch($sformatf("word %0d: bytes_valid %0d, want %0d",
				words_seen, word_if.bytes_valid, e.nbytes));
		if (word_if.last !== e.last)
			report_mismatch($sformatf("word %0d: last %b, want %b",
				words_seen, word_if.last, e.last));
		if (word_if.status !== e.status)
			report_mismatch($sformatf("word %0d: status %0d, want %0d",
				words_seen, word_if.status, e.status));
	endtask

	// monitor: checks words, predicts accepted pixels, tracks register writes
	always @(posedge clk) begin
		if (!arst_n) begin
			pix_taken   <= 1'b0;
			idle_cycles <= 0;
		end else begin
			pix_taken <= pix_if.valid && pix_if.ready;
			if (word_if.valid && word_if.ready)
				check_word();
			if (pix_if.valid && pix_if.ready) begin
				pixels_taken++;
				predict_pixel({pix_if.red, pix_if.green, pix_if.blue, pix_if.alpha});
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_WIDTH:  img_w = 32'(cfg_data);
					REG_HEIGHT: img_h = 32'(cfg_data);
					REG_MODE:   img_mode = color_mode_t'(cfg_data[0]);
					default:    ;
				endcase
			end
			if ((word_if.valid && word_if.ready) || (pix_if.valid && pix_if.ready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// pixel driver: bursts with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
		end else if (!pix_if.valid || pix_taken) begin
			if (gap_left != 0) begin
				gap_left--;
				pix_if.valid <= 1'b0;
			end else if (pixel_q.size() != 0) begin
				drv_pixel = pixel_q.pop_front();
				pix_if.red   <= drv_pixel.red;
				pix_if.green <= drv_pixel.green;
				pix_if.blue  <= drv_pixel.blue;
				pix_if.alpha <= drv_pixel.alpha;
				pix_if.valid <= 1'b1;
				if (burst_left != 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				pix_if.valid <= 1'b0;
			end
		end
	end

	// word sink: stall style changes every so often
	always @(negedge clk) begin
		pace_cycle++;
		if (pace_cycle % 97 == 0)
			pace = sink_pace_t'($urandom_range(0, 3));
		case (pace)
			PACE_FULL:   word_if.ready <= 1'b1;
			PACE_COIN:   word_if.ready <= $urandom_range(0, 1) != 0;
			PACE_THIRD:  word_if.ready <= (pace_cycle % 3) == 0;
			default:     word_if.ready <= $urandom_range(0, 7) != 0;
		endcase
	end

	task wait_idle();
		while (pixel_q.size() != 0 || pix_if.valid || word_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task write_reg(reg_idx_t idx, int unsigned val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	task program_regs(int unsigned w, int unsigned h, color_mode_t m);
		wait_idle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_MODE, m);
	endtask

	task send_random(int unsigned n);
		bmp_pixel_t p;
		repeat (n) begin
			p = $urandom;
			add_pixel(p);
		end
	endtask

	task watchdog();
		@(posedge arst_n);
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("ERROR: no request moved for %0d cycles", STALL_LIMIT);
		$display("status: fail");
		$finish;
	endtask

	initial begin
		watchdog();
	end

	initial begin
		int unsigned normal_sent, w, n;
		color_mode_t m;
		arst_n        = 1'b0;
		pix_if.valid  = 1'b0;
		pix_if.red    = '0;
		pix_if.green  = '0;
		pix_if.blue   = '0;
		pix_if.alpha  = '0;
		word_if.ready = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = REG_WIDTH;
		cfg_data      = '0;
		img_w = 1;
		img_h = 1;
		img_mode = MODE_BGR24;
		pace = PACE_FULL;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// bad dimensions before any image data
		program_regs(0, 1, MODE_BGR24);
		add_pixel('0);
		program_regs(32767, 1, MODE_BGR24);
		add_pixel('1);
		program_regs(1, 0, MODE_BGR24);
		add_pixel(32'h01020304);
		program_regs(1, 32767, MODE_BGR24);
		add_pixel(32'h80808080);

		// header at the largest image, mode picked by seed
		m = color_mode_t'($urandom_range(0, 1));
		program_regs(MAX_DIM, MAX_DIM, m);
		add_pixel('1);
		add_pixel('0);
		add_pixel(32'hA55A0FF0);
		program_regs(MAX_DIM, MAX_DIM, color_mode_t'(~m));
		send_random(2);
		// shrinking the width ends the row; each row padding length
		program_regs(1, MAX_DIM, MODE_BGR24);
		send_random(1);
		program_regs(2, MAX_DIM, MODE_BGR24);
		send_random(2);
		program_regs(3, MAX_DIM, MODE_BGR24);
		send_random(3);
		program_regs(2, MAX_DIM, MODE_BGRA32);
		send_random(2);
		normal_sent = 13;

		while (normal_sent < TARGET_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: program_regs(0, MAX_DIM, MODE_BGR24);
					1: program_regs(4, 0, MODE_BGRA32);
					2: program_regs($urandom_range(MAX_DIM + 1, 32767), MAX_DIM, MODE_BGR24);
					default: program_regs(4, $urandom_range(MAX_DIM + 1, 32767), MODE_BGRA32);
				endcase
				send_random($urandom_range(1, 3));
			end
			case ($urandom_range(0, 19))
				0:       w = MAX_DIM;
				1:       w = $urandom_range(1000, MAX_DIM);
				default: w = $urandom_range(1, 9);
			endcase
			m = color_mode_t'($urandom_range(0, 1));
			n = (w > 9) ? $urandom_range(1, 6) : $urandom_range(1, 20);
			program_regs(w, MAX_DIM, m);
			send_random(n);
			normal_sent += n;
		end

		// one row left: finish the image, then push past its end
		w = $urandom_range(1, 6);
		program_regs(w, 1, color_mode_t'($urandom_range(0, 1)));
		send_random(w);
		program_regs(w, 1, MODE_BGR24);
		send_random(3);

		wait_idle();
		if (word_q.size() != 0)
			report_mismatch($sformatf("%0d expected words never arrived", word_q.size()));
		$display("covered %0d pixels and %0d words, header in %0d-bit mode",
			pixels_taken, words_seen, hdr_bpp);
		$display("status replies: %0d bad dimension, %0d past image end, %0d errors",
			bad_dim_seen, past_end_seen, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
